// ----- rtl/svkt_pkg.sv -----
// ----------------------------------------------------------------------------
// svkt_pkg
// types and codes shared by the sorted cell key table
// ----------------------------------------------------------------------------
`default_nettype none
package svkt_pkg;

	localparam logic [1:0] KIND_ADD   = 2'd0;
	localparam logic [1:0] KIND_BOX   = 2'd1;
	localparam logic [1:0] KIND_QUERY = 2'd2;
	localparam logic [1:0] KIND_NONE  = 2'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [4:0]  x_first;
		logic [4:0]  y_first;
		logic [4:0]  z_first;
		logic [4:0]  x_second;
		logic [4:0]  y_second;
		logic [4:0]  z_second;
		logic [15:0] block_value;
	} in_word_t;

	typedef struct packed {
		logic        found;
		logic [15:0] stored_value;
		logic [12:0] entry_total;
		logic        overflow;
		logic [5:0]  low_x;
		logic [5:0]  low_y;
		logic [5:0]  low_z;
		logic [4:0]  high_x;
		logic [4:0]  high_y;
		logic [4:0]  high_z;
	} out_word_t;

endpackage
`default_nettype wire

// ----- rtl/sorted_voxel_key_table.sv -----
// ----------------------------------------------------------------------------
// sorted_voxel_key_table
// sorted table of cell keys with data and a bounding box
// ----------------------------------------------------------------------------
//  channel   dir  handshake              word
//  in        in   in_valid / in_ready    svkt_pkg::in_word_t
//  out       out  out_valid / out_ready  svkt_pkg::out_word_t
// one word at a time: the word is taken in idle, then for each cell the key is formed and,
// for adds and boxes, compared with the last entry, where an append ends; otherwise a binary
// search halves the range (search, search-wait) and then reads and judges the entry found
// an insert moves each entry above it (read, write) and then writes; every add or box
// cell ends with a step state, and the done state after the last cell raises the result
// reset clears the count, the box and the control; the memory is not cleared
// a waiting result holds the next word off until taken
`default_nettype none
module sorted_voxel_key_table #(
	parameter int EDGE = 32,
	parameter int CAPACITY = 4096,
	parameter int DATA_BITS = 16
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       in_valid,
	output logic                      in_ready,
	input  wire svkt_pkg::in_word_t   in_data,
	output logic                      out_valid,
	input  wire                       out_ready,
	output svkt_pkg::out_word_t       out_data
);
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int KMAX = 31 * (1 + EDGE + EDGE * EDGE);
	localparam int KW = $clog2(KMAX + 1);

	localparam logic [3:0] ST_IDLE = 4'd0, ST_CELL = 4'd1, ST_LASTW = 4'd2,
		ST_SRCH = 4'd3, ST_SRCHW = 4'd4, ST_DECIDE = 4'd5, ST_MVRD = 4'd6,
		ST_MVWR = 4'd7, ST_INS = 4'd8, ST_NEXT = 4'd9, ST_DONE = 4'd10;

	logic [3:0] st_q;
	logic [1:0] kind_q;
	logic [DATA_BITS-1:0] wval_q;
	logic [4:0] lo_q [3];
	logic [4:0] hi_q [3];
	logic [4:0] cx_q, cy_q, cz_q;
	logic [CW-1:0] fill_q, lo_p_q, hi_p_q, mv_q;
	logic [6:0] bl_q [3];
	logic [4:0] bh_q [3];
	logic ovf_q, found_q;
	logic [DATA_BITS-1:0] val_q;
	logic [KW-1:0] key_q;

	logic we;
	logic [AW-1:0] addr;
	logic [KW-1:0] wkey, rkey;
	logic [DATA_BITS-1:0] wdata, rdata;
	logic [KW-1:0] cell_k;
	logic [CW-1:0] mid;
	logic [4:0] first_c [3];
	logic [4:0] second_c [3];
	logic [4:0] lo_c [3];
	logic [4:0] hi_c [3];

	svkt_store #(.DEPTH(CAPACITY), .KW(KW), .DW(DATA_BITS)) u_store (
		.clk(clk), .we(we), .addr(addr), .wkey(wkey), .wdata(wdata),
		.rkey(rkey), .rdata(rdata)
	);

	assign cell_k = KW'(cx_q) + KW'(EDGE) * (KW'(cy_q) + KW'(EDGE) * KW'(cz_q));
	assign mid = lo_p_q + ((hi_p_q - lo_p_q) >> 1);
	assign in_ready = (st_q == ST_IDLE) && !out_valid;

	// box corners in either order
	always_comb begin
		first_c[0] = in_data.x_first;
		first_c[1] = in_data.y_first;
		first_c[2] = in_data.z_first;
		second_c[0] = in_data.x_second;
		second_c[1] = in_data.y_second;
		second_c[2] = in_data.z_second;
		for (int a = 0; a < 3; a++) begin
			if (in_data.kind == svkt_pkg::KIND_BOX && second_c[a] < first_c[a]) begin
				lo_c[a] = second_c[a];
			end else begin
				lo_c[a] = first_c[a];
			end
			if (in_data.kind == svkt_pkg::KIND_BOX && second_c[a] > first_c[a]) begin
				hi_c[a] = second_c[a];
			end else begin
				hi_c[a] = first_c[a];
			end
		end
	end

	always_comb begin
		we = 1'b0;
		addr = '0;
		wkey = key_q;
		wdata = wval_q;
		case (st_q)
			ST_CELL: begin
				if (kind_q != svkt_pkg::KIND_QUERY && fill_q == '0) begin
					we = 1'b1;
					wkey = cell_k;
				end else begin
					addr = AW'(fill_q - CW'(1));
				end
			end
			ST_LASTW: begin
				if (rkey < key_q && fill_q < CW'(CAPACITY)) begin
					we = 1'b1;
					addr = AW'(fill_q);
				end
			end
			ST_SRCH: addr = (lo_p_q < hi_p_q) ? AW'(mid) : AW'(lo_p_q);
			ST_DECIDE: begin
				if (kind_q != svkt_pkg::KIND_QUERY && rkey == key_q) begin
					we = 1'b1;
					addr = AW'(lo_p_q);
				end
			end
			ST_MVRD: addr = AW'(mv_q - CW'(1));
			ST_MVWR: begin
				we = 1'b1;
				addr = AW'(mv_q);
				wkey = rkey;
				wdata = rdata;
			end
			ST_INS: begin
				we = 1'b1;
				addr = AW'(lo_p_q);
			end
			default: addr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			kind_q <= svkt_pkg::KIND_ADD;
			wval_q <= '0;
			fill_q <= '0;
			out_valid <= 1'b0;
			ovf_q <= 1'b0;
			found_q <= 1'b0;
			val_q <= '0;
			key_q <= '0;
			cx_q <= '0;
			cy_q <= '0;
			cz_q <= '0;
			lo_p_q <= '0;
			hi_p_q <= '0;
			mv_q <= '0;
			for (int a = 0; a < 3; a++) begin
				bl_q[a] <= 7'(EDGE);
				bh_q[a] <= '0;
				lo_q[a] <= '0;
				hi_q[a] <= '0;
			end
		end else begin
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end else if (st_q == ST_DONE) begin
				out_valid <= 1'b1;
			end
			case (st_q)
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						kind_q <= in_data.kind;
						wval_q <= DATA_BITS'(in_data.block_value);
						ovf_q <= 1'b0;
						found_q <= 1'b0;
						val_q <= '0;
						cx_q <= lo_c[0];
						cy_q <= lo_c[1];
						cz_q <= lo_c[2];
						for (int a = 0; a < 3; a++) begin
							lo_q[a] <= lo_c[a];
							hi_q[a] <= hi_c[a];
							if (in_data.kind == svkt_pkg::KIND_ADD ||
								in_data.kind == svkt_pkg::KIND_BOX) begin
								if (7'(lo_c[a]) < bl_q[a]) bl_q[a] <= 7'(lo_c[a]);
								if (hi_c[a] > bh_q[a]) bh_q[a] <= hi_c[a];
							end
						end
						st_q <= (in_data.kind == svkt_pkg::KIND_NONE) ? ST_DONE : ST_CELL;
					end
				end
				ST_CELL: begin
					key_q <= cell_k;
					lo_p_q <= '0;
					hi_p_q <= fill_q;
					if (kind_q == svkt_pkg::KIND_QUERY) begin
						st_q <= ST_SRCH;
					end else if (fill_q == '0) begin
						fill_q <= CW'(1);
						st_q <= ST_NEXT;
					end else begin
						st_q <= ST_LASTW;
					end
				end
				ST_LASTW: begin
					if (rkey < key_q) begin
						if (fill_q < CW'(CAPACITY)) fill_q <= fill_q + CW'(1);
						else ovf_q <= 1'b1;
						st_q <= ST_NEXT;
					end else begin
						st_q <= ST_SRCH;
					end
				end
				ST_SRCH: begin
					if (lo_p_q < hi_p_q) st_q <= ST_SRCHW;
					else st_q <= ST_DECIDE;
				end
				ST_SRCHW: begin
					if (rkey < key_q) lo_p_q <= mid + CW'(1);
					else hi_p_q <= mid;
					st_q <= ST_SRCH;
				end
				ST_DECIDE: begin
					if (kind_q == svkt_pkg::KIND_QUERY) begin
						if (lo_p_q < fill_q && rkey == key_q) begin
							found_q <= 1'b1;
							val_q <= rdata;
						end
						st_q <= ST_DONE;
					end else if (rkey == key_q) begin
						st_q <= ST_NEXT;
					end else if (fill_q >= CW'(CAPACITY)) begin
						ovf_q <= 1'b1;
						st_q <= ST_NEXT;
					end else begin
						mv_q <= fill_q;
						st_q <= ST_MVRD;
					end
				end
				ST_MVRD: st_q <= ST_MVWR;
				ST_MVWR: begin
					mv_q <= mv_q - CW'(1);
					st_q <= (mv_q - CW'(1) == lo_p_q) ? ST_INS : ST_MVRD;
				end
				ST_INS: begin
					fill_q <= fill_q + CW'(1);
					st_q <= ST_NEXT;
				end
				ST_NEXT: begin
					if (kind_q == svkt_pkg::KIND_BOX && cx_q != hi_q[0]) begin
						cx_q <= cx_q + 5'd1;
						st_q <= ST_CELL;
					end else if (kind_q == svkt_pkg::KIND_BOX && cy_q != hi_q[1]) begin
						cx_q <= lo_q[0];
						cy_q <= cy_q + 5'd1;
						st_q <= ST_CELL;
					end else if (kind_q == svkt_pkg::KIND_BOX && cz_q != hi_q[2]) begin
						cx_q <= lo_q[0];
						cy_q <= lo_q[1];
						cz_q <= cz_q + 5'd1;
						st_q <= ST_CELL;
					end else begin
						st_q <= ST_DONE;
					end
				end
				ST_DONE: st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		out_data.found = found_q;
		out_data.stored_value = 16'(val_q);
		out_data.entry_total = 13'(fill_q);
		out_data.overflow = ovf_q;
		out_data.low_x = bl_q[0][5:0];
		out_data.low_y = bl_q[1][5:0];
		out_data.low_z = bl_q[2][5:0];
		out_data.high_x = bh_q[0];
		out_data.high_y = bh_q[1];
		out_data.high_z = bh_q[2];
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(CAPACITY)) else $error("fill above capacity");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> st_q == ST_IDLE) else $error("result while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("result word moved while waiting");
endmodule
`default_nettype wire

// ----- rtl/svkt_store.sv -----
// ----------------------------------------------------------------------------
// svkt_store
// entry memory: key and data per entry, one port, registered read
// ----------------------------------------------------------------------------
`default_nettype none
module svkt_store #(
	parameter int DEPTH = 4096,
	parameter int KW = 15,
	parameter int DW = 16
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] addr,
	input  wire [KW-1:0]            wkey,
	input  wire [DW-1:0]            wdata,
	output logic [KW-1:0]           rkey,
	output logic [DW-1:0]           rdata
);
	logic [KW+DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= {wkey, wdata};
		end
		{rkey, rdata} <= mem[addr];
	end
endmodule
`default_nettype wire
